// File: sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Operation and status codes, and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_END   = 3'd1;
  localparam logic [2:0] OP_INS_AT    = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_END   = 3'd4;
  localparam logic [2:0] OP_DEL_AT    = 3'd5;
  localparam logic [2:0] OP_SEARCH    = 3'd6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_POS_NF    = 3'd3;
  localparam logic [2:0] ST_VAL_NF    = 3'd4;

  typedef enum logic [1:0] {
    K_NONE,
    K_INS,
    K_DEL,
    K_SRCH
  } kind_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr_val;
    logic dec;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic direct;
    logic last_rd;
    logic is_ins;
    logic is_del;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/ple_if.sv
// ----------------------------------------------------------------------------
// Positional list engine channels
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  opcode;
  logic        [4:0]  position;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface ple_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [31:0] removed_value;
  logic        [3:0]  found_index;
  logic        [4:0]  entry_count;

  modport source (output valid, output status, output removed_value, output found_index,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value, input found_index,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// File: sv/ple_ctrl.sv
// ----------------------------------------------------------------------------
// Positional list engine controller
// Sequences one operation: accept, entry scan, final write and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_ready,
  input  ple_pkg::sts_t sts,
  output ple_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.skip) begin
          state_nxt = S_DONE;
        end else if (sts.direct) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.last_rd) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.is_ins) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.dec   = sts.is_del;
          state_nxt = S_DONE;
        end
      end
      S_WRITE: begin
        cmd.wr_val = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/ple_dpath.sv
// ----------------------------------------------------------------------------
// Positional list engine datapath
// Entry memory, length count, scan pointer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_dpath #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  input  ple_pkg::cmd_t      cmd,
  output ple_pkg::sts_t      sts,
  input  wire         [2:0]  in_opcode,
  input  wire         [4:0]  in_position,
  input  wire         [31:0] in_value,
  output logic               out_valid,
  input  wire                out_ready,
  output logic        [2:0]  out_status,
  output logic        [31:0] out_removed_value,
  output logic        [3:0]  out_found_index,
  output logic        [4:0]  out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > 5) ? LW : 5;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [LW-1:0]         len_r;
  ple_pkg::kind_t        kind_r;
  logic [2:0]            err_r;
  logic                  direct_r;
  logic [AW-1:0]         p_r;
  logic [AW-1:0]         ra_r;
  logic [AW-1:0]         rdaddr_r;
  logic                  rv_r;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic                  found_r;
  logic [AW-1:0]         idx_r;
  logic                  out_valid_r;
  logic [2:0]            out_status_r;
  logic [31:0]           out_rem_r;
  logic [3:0]            out_idx_r;
  logic [4:0]            out_cnt_r;

  logic [CW-1:0]         len_c;
  logic [CW-1:0]         lenm1_c;
  logic [CW-1:0]         pos_c;
  logic [CW-1:0]         p_c;
  logic [CW-1:0]         ra_c;
  logic [CW-1:0]         idx_c;
  ple_pkg::kind_t        kind_c;
  logic [2:0]            err_c;
  logic [AW-1:0]         ra_init;
  logic [DATA_WIDTH-1:0] val_w;
  logic [31:0]           rem_n;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [2:0]            fin_status;

  assign len_c   = CW'(len_r);
  assign lenm1_c = len_c - CW'(1);
  assign pos_c   = CW'(in_position);
  assign ra_c    = CW'(ra_r);
  assign idx_c   = CW'(idx_r);

  if (DATA_WIDTH > 32) begin : g_wide
    assign val_w = {{(DATA_WIDTH - 32){in_value[31]}}, in_value};
    assign rem_n = rem_r[31:0];
  end else if (DATA_WIDTH == 32) begin : g_same
    assign val_w = in_value;
    assign rem_n = rem_r;
  end else begin : g_narrow
    assign val_w = in_value[DATA_WIDTH-1:0];
    assign rem_n = {{(32 - DATA_WIDTH){rem_r[DATA_WIDTH-1]}}, rem_r};
  end

  always_comb begin
    kind_c = ple_pkg::K_NONE;
    p_c    = '0;
    case (in_opcode)
      ple_pkg::OP_INS_FRONT: begin
        kind_c = ple_pkg::K_INS;
      end
      ple_pkg::OP_INS_END: begin
        kind_c = ple_pkg::K_INS;
        p_c    = len_c;
      end
      ple_pkg::OP_INS_AT: begin
        kind_c = ple_pkg::K_INS;
        p_c    = pos_c;
      end
      ple_pkg::OP_DEL_FRONT: begin
        kind_c = ple_pkg::K_DEL;
      end
      ple_pkg::OP_DEL_END: begin
        kind_c = ple_pkg::K_DEL;
        p_c    = lenm1_c;
      end
      ple_pkg::OP_DEL_AT: begin
        kind_c = ple_pkg::K_DEL;
        p_c    = pos_c;
      end
      ple_pkg::OP_SEARCH: begin
        kind_c = ple_pkg::K_SRCH;
      end
      default: begin
        kind_c = ple_pkg::K_NONE;
      end
    endcase
  end

  always_comb begin
    err_c   = ple_pkg::ST_OK;
    ra_init = '0;
    case (kind_c)
      ple_pkg::K_INS: begin
        ra_init = lenm1_c[AW-1:0];
        if (len_c >= CW'(CAPACITY)) begin
          err_c = ple_pkg::ST_FULL;
        end else if (p_c > len_c) begin
          err_c = ple_pkg::ST_POS_NF;
        end
      end
      ple_pkg::K_DEL: begin
        ra_init = p_c[AW-1:0];
        if (len_c == '0) begin
          err_c = ple_pkg::ST_EMPTY;
        end else if (p_c >= len_c) begin
          err_c = ple_pkg::ST_POS_NF;
        end
      end
      ple_pkg::K_SRCH: begin
        if (len_c == '0) begin
          err_c = ple_pkg::ST_EMPTY;
        end
      end
      default: begin
        err_c = ple_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    sts.skip     = (err_r != ple_pkg::ST_OK) || (kind_r == ple_pkg::K_NONE);
    sts.direct   = direct_r;
    sts.is_ins   = (kind_r == ple_pkg::K_INS);
    sts.is_del   = (kind_r == ple_pkg::K_DEL);
    sts.last_rd  = (kind_r == ple_pkg::K_INS) ? (ra_r == p_r) : (ra_c == lenm1_c);
    sts.out_busy = out_valid_r && !out_ready;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_r;
    wr_data = val_r;
    if (cmd.wr_val) begin
      wr_en = 1'b1;
    end else if (rv_r && kind_r == ple_pkg::K_INS) begin
      wr_en   = 1'b1;
      wr_addr = rdaddr_r + AW'(1);
      wr_data = rdata_r;
    end else if (rv_r && kind_r == ple_pkg::K_DEL && rdaddr_r != p_r) begin
      wr_en   = 1'b1;
      wr_addr = rdaddr_r - AW'(1);
      wr_data = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r  <= mem[ra_r];
    rdaddr_r <= ra_r;
  end

  always_comb begin
    fin_status = err_r;
    if (err_r == ple_pkg::ST_OK && kind_r == ple_pkg::K_SRCH && !found_r) begin
      fin_status = ple_pkg::ST_VAL_NF;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= kind_c;
      err_r    <= err_c;
      direct_r <= (p_c == len_c);
      p_r      <= p_c[AW-1:0];
      ra_r     <= ra_init;
      val_r    <= val_w;
      rem_r    <= '0;
      idx_r    <= '0;
    end else if (cmd.rd) begin
      ra_r <= (kind_r == ple_pkg::K_INS) ? (ra_r - AW'(1)) : (ra_r + AW'(1));
    end
    if (rv_r && kind_r == ple_pkg::K_DEL && rdaddr_r == p_r) begin
      rem_r <= rdata_r;
    end
    if (rv_r && kind_r == ple_pkg::K_SRCH && !found_r && rdata_r == val_r) begin
      idx_r <= rdaddr_r;
    end
    if (cmd.publish) begin
      out_status_r <= fin_status;
      out_rem_r    <= rem_n;
      out_idx_r    <= idx_c[3:0];
      out_cnt_r    <= len_c[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rv_r <= cmd.rd;
      if (cmd.wr_val) begin
        len_r <= len_r + LW'(1);
      end else if (cmd.dec) begin
        len_r <= len_r - LW'(1);
      end
      if (cmd.load) begin
        found_r <= 1'b0;
      end else if (rv_r && kind_r == ple_pkg::K_SRCH && rdata_r == val_r) begin
        found_r <= 1'b1;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_rem_r;
  assign out_found_index   = out_idx_r;
  assign out_entry_count   = out_cnt_r;

endmodule

`default_nettype wire

// File: sv/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Requests arrive on in_chan (opcode, position, value) and each one yields
// exactly one transaction on out_chan (status, removed_value, found_index,
// entry_count); a transaction moves when valid and ready are high together
// at a rising edge of clk. One request is worked on at a time. Entries live
// in a memory with a registered read and are moved or compared one at a
// time. A request that fails its checks or has an unused opcode goes straight
// to its result, an insert at the end of the list writes with no scan, and
// any other insert, delete or search first scans the entries that it moves
// or reads. The next request is taken once the result is registered, also
// while that result still waits; it stalls only at its own hand-off until
// the receiver has taken the earlier result. Synchronous active-low reset
// empties the list and drops any pending result, and no request is taken
// while it is held.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire clk,
  input  wire rst_n,
  ple_in_if.sink    in_chan,
  ple_out_if.source out_chan
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;
  logic [2:0]    out_status;
  logic [31:0]   out_removed_value;
  logic [3:0]    out_found_index;
  logic [4:0]    out_entry_count;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ple_dpath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_chan.opcode),
    .in_position       (in_chan.position),
    .in_value          (in_chan.value),
    .out_valid         (out_valid),
    .out_ready         (out_chan.ready),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_found_index   (out_found_index),
    .out_entry_count   (out_entry_count)
  );

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid;
  assign out_chan.status        = out_status;
  assign out_chan.removed_value = out_removed_value;
  assign out_chan.found_index   = out_found_index;
  assign out_chan.entry_count   = out_entry_count;

endmodule

`default_nettype wire

// File: sim/positional_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives list operations into the engine over its request channel, with
// random idle cycles on both sides and one long receiver hold-off, and keeps
// a shadow copy of the list from which every reply is predicted. Each reply
// transaction is checked field by field against the oldest prediction.
// A short directed sequence covers the empty, out-of-range and unused-opcode
// cases; random bursts that lean towards growing or shrinking the list then
// take it between empty and full many times.
// ----------------------------------------------------------------------------

module positional_list_engine_tb;

  localparam int          LIST_CAP     = 16;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int          LIMIT_CYCLES = 400000;
  localparam logic [2:0]  OP_UNUSED    = 3'd7;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] removed_value;
    logic        [3:0]  found_index;
    logic        [4:0]  entry_count;
  } list_reply_t;

  class list_shadow;
    logic signed [31:0] entries [LIST_CAP];
    int unsigned        length;
    list_reply_t        pending_replies [$];
    int unsigned        error_count;

    function new();
      length      = 0;
      error_count = 0;
    endfunction

    function void flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    function list_reply_t insert_entry(int unsigned pos, logic signed [31:0] val);
      list_reply_t r;
      int unsigned i;
      r = '0;
      if (length >= LIST_CAP) begin
        r.status = ple_pkg::ST_FULL;
      end else if (pos > length) begin
        r.status = ple_pkg::ST_POS_NF;
      end else begin
        for (i = length; i > pos; i--) entries[i] = entries[i - 1];
        entries[pos] = val;
        length++;
        r.status = ple_pkg::ST_OK;
      end
      r.entry_count = 5'(length);
      return r;
    endfunction

    function list_reply_t remove_entry(int unsigned pos);
      list_reply_t r;
      int unsigned i;
      r = '0;
      if (length == 0) begin
        r.status = ple_pkg::ST_EMPTY;
      end else if (pos >= length) begin
        r.status = ple_pkg::ST_POS_NF;
      end else begin
        r.removed_value = entries[pos];
        for (i = pos; i + 1 < length; i++) entries[i] = entries[i + 1];
        length--;
        r.status = ple_pkg::ST_OK;
      end
      r.entry_count = 5'(length);
      return r;
    endfunction

    function void note_request(logic [2:0] op, logic [4:0] pos, logic signed [31:0] val);
      list_reply_t r;
      int unsigned i;
      bit          hit;
      r = '0;
      case (op)
        ple_pkg::OP_INS_FRONT: r = insert_entry(0, val);
        ple_pkg::OP_INS_END:   r = insert_entry(length, val);
        ple_pkg::OP_INS_AT:    r = insert_entry(pos, val);
        ple_pkg::OP_DEL_FRONT: r = remove_entry(0);
        ple_pkg::OP_DEL_END:   r = remove_entry(length == 0 ? 0 : length - 1);
        ple_pkg::OP_DEL_AT:    r = remove_entry(pos);
        ple_pkg::OP_SEARCH: begin
          if (length == 0) begin
            r.status = ple_pkg::ST_EMPTY;
          end else begin
            hit = 1'b0;
            for (i = 0; i < length && !hit; i++) begin
              if (entries[i] == val) begin
                hit           = 1'b1;
                r.found_index = 4'(i);
              end
            end
            r.status = hit ? ple_pkg::ST_OK : ple_pkg::ST_VAL_NF;
          end
          r.entry_count = 5'(length);
        end
        default: r.entry_count = 5'(length);
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(list_reply_t got);
      list_reply_t want;
      if (pending_replies.size() == 0) begin
        flag_error($sformatf("Unexpected reply: status %0d removed %0d index %0d count %0d",
                             got.status, got.removed_value, got.found_index,
                             got.entry_count));
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.removed_value !== want.removed_value ||
          got.found_index !== want.found_index || got.entry_count !== want.entry_count)
        flag_error($sformatf({"Reply mismatch: expected status %0d removed %0d index %0d ",
                              "count %0d, got status %0d removed %0d index %0d count %0d"},
                             want.status, want.removed_value, want.found_index,
                             want.entry_count, got.status, got.removed_value,
                             got.found_index, got.entry_count));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ple_in_if  req_if ();
  ple_out_if rsp_if ();

  positional_list_engine #(
    .CAPACITY   (LIST_CAP),
    .DATA_WIDTH (32)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if)
  );

  list_shadow  sb;
  bit          idle_enabled;
  int          hold_off_cycles;
  int unsigned cycle_count;

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.opcode      = '0;
    req_if.position    = '0;
    req_if.value       = '0;
    rsp_if.ready       = 1'b0;
    idle_enabled       = 1'b1;
    hold_off_cycles    = 0;
    cycle_count        = 0;
    sb                 = new();
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver's ready, with random idling and the long hold-off.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      rsp_if.ready    <= 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      rsp_if.ready <= !(idle_enabled && $urandom_range(99) < 34);
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_reply({rsp_if.status, rsp_if.removed_value, rsp_if.found_index,
                      rsp_if.entry_count});
  end

  task automatic send_request(input logic [2:0] op, input logic [4:0] pos,
                              input logic signed [31:0] val);
    @(negedge clk);
    while (idle_enabled && $urandom_range(99) < 34) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.position <= pos;
    req_if.value    <= val;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(op, pos, val);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5, 6: return $signed(32'($urandom_range(7))) - 32'sd4;
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    int               burst_left;
    int               burst_mode;
    int               ins_pct;
    int               del_pct;
    int               roll;
    logic [2:0]       op;
    logic [4:0]       pos;
    logic signed [31:0] val;

    burst_left = 0;
    burst_mode = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Operations on the empty list, then a short list built from the extremes.
    send_request(ple_pkg::OP_SEARCH,    5'd0,  32'sd5);
    send_request(ple_pkg::OP_DEL_FRONT, 5'd0,  32'sd0);
    send_request(ple_pkg::OP_DEL_END,   5'd0,  32'sd0);
    send_request(ple_pkg::OP_DEL_AT,    5'd0,  32'sd0);
    send_request(ple_pkg::OP_INS_AT,    5'd1,  32'sd9);
    send_request(OP_UNUSED,             5'd31, -32'sd1);
    send_request(ple_pkg::OP_INS_AT,    5'd0,  32'sh7fffffff);
    send_request(ple_pkg::OP_INS_FRONT, 5'd0,  32'sh80000000);
    send_request(ple_pkg::OP_INS_END,   5'd0,  -32'sd1);
    send_request(ple_pkg::OP_INS_AT,    5'd3,  32'sd0);
    send_request(ple_pkg::OP_INS_AT,    5'd31, 32'sd7);
    send_request(ple_pkg::OP_SEARCH,    5'd0,  32'sh80000000);
    send_request(ple_pkg::OP_SEARCH,    5'd0,  32'sd0);
    send_request(ple_pkg::OP_SEARCH,    5'd0,  32'sd12345);
    send_request(ple_pkg::OP_DEL_AT,    5'd31, 32'sd0);
    send_request(ple_pkg::OP_DEL_AT,    5'd4,  32'sd0);
    send_request(ple_pkg::OP_DEL_AT,    5'd1,  32'sd0);
    send_request(ple_pkg::OP_DEL_END,   5'd0,  32'sd0);
    send_request(ple_pkg::OP_DEL_FRONT, 5'd0,  32'sd0);
    send_request(ple_pkg::OP_DEL_FRONT, 5'd0,  32'sd0);
    send_request(ple_pkg::OP_DEL_END,   5'd0,  32'sd0);

    // Random bursts that grow, shrink or churn the list.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(60, 20);
        burst_mode = $urandom_range(2);
      end
      burst_left--;
      idle_enabled = !(n >= 500 && n < 800);
      if (n == 150) hold_off_cycles = 400;

      ins_pct = (burst_mode == 0) ? 60 : (burst_mode == 1) ? 20 : 40;
      del_pct = (burst_mode == 0) ? 20 : (burst_mode == 1) ? 60 : 40;
      roll    = $urandom_range(99);
      if (roll < ins_pct)
        op = ple_pkg::OP_INS_FRONT + 3'($urandom_range(2));
      else if (roll < ins_pct + del_pct)
        op = ple_pkg::OP_DEL_FRONT + 3'($urandom_range(2));
      else if (roll < 97)
        op = ple_pkg::OP_SEARCH;
      else
        op = OP_UNUSED;

      if ($urandom_range(4) == 0)
        pos = 5'($urandom_range(31));
      else
        pos = 5'($urandom_range(sb.length + 1));

      if (op == ple_pkg::OP_SEARCH && sb.length > 0 && $urandom_range(1) == 1)
        val = sb.entries[$urandom_range(sb.length - 1)];
      else
        val = pick_value();

      send_request(op, pos, val);
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    idle_enabled = 1'b1;

    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (LIST_CAP + 8) @(posedge clk);

    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
